// ----- rtl/gregorian_julian_day_converter_unit_defines.svh -----
// Assertion macros shared by the checker of the date converter.
// Depends on nothing; included by the files that hold assertions.
`ifndef GREGORIAN_JULIAN_DAY_CONVERTER_UNIT_DEFINES_SVH
`define GREGORIAN_JULIAN_DAY_CONVERTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// The consequent must hold after the antecedent, delayed by the argument n.
`define ASSERT_DELAYED(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("%m: delayed check failed");

`endif

// ----- rtl/gjdc_pkg.sv -----
// Types, constants and tables of the Gregorian date and Julian day number converter.
// Depends on nothing; used by every module of the block.
package gjdc_pkg;

   localparam logic OP_DATE_TO_JDN = 1'b0;
   localparam logic OP_JDN_TO_DATE = 1'b1;

   localparam logic [15:0] YEAR_LAST = 16'd9999;
   localparam logic [22:0] JDN_FIRST = 23'd1721426;
   localparam logic [22:0] JDN_LAST = 23'd5373484;
   localparam logic [22:0] JDN_DAY_ZERO = 23'd1721119;

   localparam logic [13:0] YEAR_BIAS = 14'd4800;
   localparam logic [23:0] JDN_EPOCH_OFFSET = 24'd32045;
   localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
   localparam logic [17:0] DAYS_PER_CENT = 18'd146097;
   localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
   localparam logic [7:0] DAYS_PER_FIVE_MONTHS = 8'd153;

   // Reciprocals, each scaled by the power of two named beside it.
   localparam logic [13:0] RECIP_100 = 14'd10486;    // 2^20 / 100, also 2^22 / 400
   localparam logic [6:0] RECIP_CENT = 7'd114;       // 2^24 / 146097, low by at most one
   localparam logic [13:0] RECIP_QUAD = 14'd11483;   // 2^24 / 1461, low by at most one
   localparam logic [12:0] RECIP_153 = 13'd6854;     // 2^20 / 153, exact here
   localparam logic [7:0] RECIP_5 = 8'd205;          // 2^10 / 5, exact here

   localparam logic [2:0] SUNDAY = 3'd1;
   localparam logic [2:0] SATURDAY = 3'd7;

   localparam int unsigned TRAIL_DEPTH = 6;

   typedef struct packed {
      logic op;
      logic [15:0] year_in;
      logic [3:0] month_in;
      logic [4:0] day_in;
      logic [22:0] day_number_in;
   } req_type;

   typedef struct packed {
      logic [22:0] day_number_out;
      logic [13:0] year_out;
      logic [3:0] month_out;
      logic [4:0] day_out;
      logic [2:0] weekday;
      logic is_business_day;
      logic range_error;
   } rsp_type;

   typedef struct packed {
      logic [22:0] jdn;
      logic err;
   } jdn_word_type;

   typedef struct packed {
      logic [22:0] jdn;
      logic [2:0] rem;
      logic err;
   } trail_type;

   // Days before the first of a March-based month: (153 * m + 2) / 5.
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] days;
      case (m)
         4'd0: days = 9'd0;
         4'd1: days = 9'd31;
         4'd2: days = 9'd61;
         4'd3: days = 9'd92;
         4'd4: days = 9'd122;
         4'd5: days = 9'd153;
         4'd6: days = 9'd184;
         4'd7: days = 9'd214;
         4'd8: days = 9'd245;
         4'd9: days = 9'd275;
         4'd10: days = 9'd306;
         4'd11: days = 9'd337;
         4'd12: days = 9'd367;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ----- rtl/gjdc_date_to_jdn.sv -----
// Two pipeline stages that turn a request word into a Julian day number and a range flag.
// Depends on gjdc_pkg.
module gjdc_date_to_jdn (
   input logic clock,
   input logic reset,
   input logic in_valid,
   input gjdc_pkg::req_type in_data,
   output logic out_valid,
   output gjdc_pkg::jdn_word_type out_word
);

   logic march_shift;
   logic [14:0] y_sum;
   logic [4:0] m_sum;
   logic err_date;
   logic err_jdn;

   logic s1_valid_ff, s1_valid_in;
   logic s1_op_ff, s1_op_in;
   logic s1_err_ff, s1_err_in;
   logic [13:0] s1_y_ff, s1_y_in;
   logic [27:0] s1_prod_ff, s1_prod_in;
   logic [8:0] s1_offset_ff, s1_offset_in;
   logic [4:0] s1_day_ff, s1_day_in;
   logic [22:0] s1_jin_ff, s1_jin_in;

   logic [23:0] jdn_sum;
   logic s2_valid_ff, s2_valid_in;
   gjdc_pkg::jdn_word_type s2_word_ff, s2_word_in;

   always_comb begin
      march_shift = (in_data.month_in <= 4'd2);
      y_sum = 15'(in_data.year_in[13:0]) + 15'(gjdc_pkg::YEAR_BIAS) - 15'(march_shift);
      m_sum = 5'(in_data.month_in) + (march_shift ? 5'd12 : 5'd0) - 5'd3;
      err_date = (in_data.year_in == 16'd0) || (in_data.year_in > gjdc_pkg::YEAR_LAST);
      err_jdn = (in_data.day_number_in < gjdc_pkg::JDN_FIRST) ||
                (in_data.day_number_in > gjdc_pkg::JDN_LAST);
      s1_valid_in = in_valid;
      s1_op_in = in_data.op;
      s1_err_in = (in_data.op == gjdc_pkg::OP_JDN_TO_DATE) ? err_jdn : err_date;
      s1_y_in = y_sum[13:0];
      s1_prod_in = 28'(y_sum[13:0]) * 28'(gjdc_pkg::RECIP_100);
      s1_offset_in = gjdc_pkg::month_offset(m_sum[3:0]);
      s1_day_in = in_data.day_in;
      s1_jin_in = in_data.day_number_in;
   end

   always_comb begin
      jdn_sum = 24'(s1_day_ff) + 24'(s1_offset_ff)
              + 24'(s1_y_ff) * 24'(gjdc_pkg::DAYS_PER_YEAR)
              + 24'(s1_y_ff[13:2])
              - 24'(s1_prod_ff[27:20])
              + 24'(s1_prod_ff[27:22])
              - gjdc_pkg::JDN_EPOCH_OFFSET;
      s2_valid_in = s1_valid_ff;
      s2_word_in.jdn = (s1_op_ff == gjdc_pkg::OP_JDN_TO_DATE) ? s1_jin_ff : jdn_sum[22:0];
      s2_word_in.err = s1_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff <= s1_op_in;
      s1_err_ff <= s1_err_in;
      s1_y_ff <= s1_y_in;
      s1_prod_ff <= s1_prod_in;
      s1_offset_ff <= s1_offset_in;
      s1_day_ff <= s1_day_in;
      s1_jin_ff <= s1_jin_in;
      s2_word_ff <= s2_word_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_word = s2_word_ff;

endmodule

// ----- rtl/gjdc_jdn_to_date.sv -----
// Seven pipeline stages that split a Julian day number into date, weekday and flags.
// Depends on gjdc_pkg.
module gjdc_jdn_to_date (
   input logic clock,
   input logic reset,
   input logic in_valid,
   input gjdc_pkg::jdn_word_type in_word,
   output logic out_strobe,
   output gjdc_pkg::rsp_type out_data
);

   logic valid_ff [gjdc_pkg::TRAIL_DEPTH];
   gjdc_pkg::trail_type trail_ff [gjdc_pkg::TRAIL_DEPTH];
   gjdc_pkg::trail_type trail_in;

   logic [23:0] wd_base;
   logic [5:0] wd_sum1;
   logic [3:0] wd_sum2;
   logic [3:0] wd_sum3;
   logic [22:0] j_in;
   logic [30:0] cent_prod;
   logic [23:0] p1_x_ff, p1_x_in;
   logic [6:0] p1_q_ff, p1_q_in;

   logic [24:0] cent_rem;
   logic [6:0] p2_cent_ff, p2_cent_in;
   logic [17:0] p2_r_ff, p2_r_in;

   logic [17:0] quad_x;
   logic [31:0] quad_prod;
   logic [17:0] p3_x2_ff, p3_x2_in;
   logic [6:0] p3_yq_ff, p3_yq_in;
   logic [6:0] p3_cent_ff;

   logic [17:0] quad_rem;
   logic [10:0] day_of_year;
   logic [8:0] p4_d3_ff, p4_d3_in;
   logic [6:0] p4_yy_ff, p4_yy_in;
   logic [6:0] p4_cent_ff;

   logic [10:0] five_x;
   logic [23:0] month_prod;
   logic [10:0] p5_x3_ff, p5_x3_in;
   logic [3:0] p5_m_ff, p5_m_in;
   logic [13:0] p5_year_ff, p5_year_in;

   logic [10:0] month_rem;
   logic [7:0] p6_d4_ff, p6_d4_in;
   logic [3:0] p6_m_ff;
   logic [13:0] p6_year_ff;

   logic [14:0] day_prod;
   logic [2:0] wd;
   gjdc_pkg::rsp_type rsp_ff, rsp_in;
   logic strobe_ff;

   // Weekday: (jdn + 1) mod 7 by folding octal digits, since 8 is 1 mod 7.
   always_comb begin
      wd_base = 24'(in_word.jdn) + 24'd1;
      wd_sum1 = '0;
      for (int i = 0; i < 8; i++) begin
         wd_sum1 = wd_sum1 + 6'(wd_base[3*i +: 3]);
      end
      wd_sum2 = 4'(wd_sum1[5:3]) + 4'(wd_sum1[2:0]);
      wd_sum3 = 4'(wd_sum2[3]) + 4'(wd_sum2[2:0]);
      trail_in.jdn = in_word.jdn;
      trail_in.rem = (wd_sum3 >= 4'd7) ? 3'(wd_sum3 - 4'd7) : wd_sum3[2:0];
      trail_in.err = in_word.err;
      j_in = in_word.jdn - gjdc_pkg::JDN_DAY_ZERO;
      p1_x_in = {j_in[21:0], 2'b00} - 24'd1;
      cent_prod = 31'(p1_x_in) * 31'(gjdc_pkg::RECIP_CENT);
      p1_q_in = cent_prod[30:24];
   end

   // The quotient estimate is low by at most one, so one compare corrects it.
   always_comb begin
      cent_rem = 25'(p1_x_ff) - 25'(p1_q_ff) * 25'(gjdc_pkg::DAYS_PER_CENT);
      if (cent_rem >= 25'(gjdc_pkg::DAYS_PER_CENT)) begin
         p2_cent_in = p1_q_ff + 7'd1;
         p2_r_in = 18'(cent_rem - 25'(gjdc_pkg::DAYS_PER_CENT));
      end else begin
         p2_cent_in = p1_q_ff;
         p2_r_in = cent_rem[17:0];
      end
   end

   always_comb begin
      quad_x = {p2_r_ff[17:2], 2'b11};
      quad_prod = 32'(quad_x) * 32'(gjdc_pkg::RECIP_QUAD);
      p3_x2_in = quad_x;
      p3_yq_in = quad_prod[30:24];
   end

   always_comb begin
      quad_rem = p3_x2_ff - 18'(p3_yq_ff) * 18'(gjdc_pkg::DAYS_PER_QUAD);
      if (quad_rem >= 18'(gjdc_pkg::DAYS_PER_QUAD)) begin
         p4_yy_in = p3_yq_ff + 7'd1;
         day_of_year = 11'(quad_rem - 18'(gjdc_pkg::DAYS_PER_QUAD));
      end else begin
         p4_yy_in = p3_yq_ff;
         day_of_year = quad_rem[10:0];
      end
      p4_d3_in = 9'(day_of_year[10:2]) + 9'd1;
   end

   always_comb begin
      five_x = 11'(p4_d3_ff) * 11'd5 - 11'd3;
      month_prod = 24'(five_x) * 24'(gjdc_pkg::RECIP_153);
      p5_x3_in = five_x;
      p5_m_in = month_prod[23:20];
      p5_year_in = 14'(p4_cent_ff) * 14'd100 + 14'(p4_yy_ff);
   end

   always_comb begin
      month_rem = p5_x3_ff - 11'(p5_m_ff) * 11'(gjdc_pkg::DAYS_PER_FIVE_MONTHS);
      p6_d4_in = month_rem[7:0];
   end

   always_comb begin
      day_prod = 15'(p6_d4_ff) * 15'(gjdc_pkg::RECIP_5);
      wd = trail_ff[gjdc_pkg::TRAIL_DEPTH-1].rem + 3'd1;
      rsp_in = '0;
      if (trail_ff[gjdc_pkg::TRAIL_DEPTH-1].err) begin
         rsp_in.range_error = 1'b1;
      end else begin
         rsp_in.day_number_out = trail_ff[gjdc_pkg::TRAIL_DEPTH-1].jdn;
         rsp_in.day_out = day_prod[14:10] + 5'd1;
         if (p6_m_ff < 4'd10) begin
            rsp_in.month_out = p6_m_ff + 4'd3;
            rsp_in.year_out = p6_year_ff;
         end else begin
            rsp_in.month_out = p6_m_ff - 4'd9;
            rsp_in.year_out = p6_year_ff + 14'd1;
         end
         rsp_in.weekday = wd;
         rsp_in.is_business_day = (wd != gjdc_pkg::SUNDAY) && (wd != gjdc_pkg::SATURDAY);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < gjdc_pkg::TRAIL_DEPTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
         strobe_ff <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < gjdc_pkg::TRAIL_DEPTH; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         strobe_ff <= valid_ff[gjdc_pkg::TRAIL_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      trail_ff[0] <= trail_in;
      for (int k = 1; k < gjdc_pkg::TRAIL_DEPTH; k++) begin
         trail_ff[k] <= trail_ff[k-1];
      end
      p1_x_ff <= p1_x_in;
      p1_q_ff <= p1_q_in;
      p2_cent_ff <= p2_cent_in;
      p2_r_ff <= p2_r_in;
      p3_x2_ff <= p3_x2_in;
      p3_yq_ff <= p3_yq_in;
      p3_cent_ff <= p2_cent_ff;
      p4_d3_ff <= p4_d3_in;
      p4_yy_ff <= p4_yy_in;
      p4_cent_ff <= p3_cent_ff;
      p5_x3_ff <= p5_x3_in;
      p5_m_ff <= p5_m_in;
      p5_year_ff <= p5_year_in;
      p6_d4_ff <= p6_d4_in;
      p6_m_ff <= p5_m_ff;
      p6_year_ff <= p5_year_ff;
      rsp_ff <= rsp_in;
   end

   assign out_strobe = strobe_ff;
   assign out_data = rsp_ff;

endmodule

// ----- rtl/gregorian_julian_day_converter_unit.sv -----
// A result word is strobed at the end of the pipeline after start is taken.
// Throughput: one word per cycle; the nine-stage pipeline never stalls, busy is low in use.
// Reset is synchronous: it clears all valid bits, and busy is high in the cycle after
// a reset cycle. The receiver cannot stall, so each result is shown for one cycle only.
// Depends on gjdc_pkg, gjdc_date_to_jdn and gjdc_jdn_to_date.
module gregorian_julian_day_converter_unit (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input gjdc_pkg::req_type req_data,
   output logic rsp_strobe,
   output gjdc_pkg::rsp_type rsp_data
);

   logic busy_ff, busy_in;
   logic accept;
   logic mid_valid;
   gjdc_pkg::jdn_word_type mid_word;

   assign busy_in = reset;
   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   gjdc_date_to_jdn u_date_to_jdn (
      .clock(clock),
      .reset(reset),
      .in_valid(accept),
      .in_data(req_data),
      .out_valid(mid_valid),
      .out_word(mid_word)
   );

   gjdc_jdn_to_date u_jdn_to_date (
      .clock(clock),
      .reset(reset),
      .in_valid(mid_valid),
      .in_word(mid_word),
      .out_strobe(rsp_strobe),
      .out_data(rsp_data)
   );

   assign busy = busy_ff;

endmodule

// ----- rtl/gjdc_checker.sv -----
// Port-level checks of the date converter and the bind that attaches them.
// Depends on gjdc_pkg and gregorian_julian_day_converter_unit_defines.svh.
`include "gregorian_julian_day_converter_unit_defines.svh"

module gjdc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input gjdc_pkg::req_type req_data,
   input logic rsp_strobe,
   input gjdc_pkg::rsp_type rsp_data
);

   `ASSERT_DELAYED(a_rsp_follows_req, clock, reset, start && !busy, 9, rsp_strobe)
   `ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_strobe, $past(start && !busy, 9))
   `ASSERT_IMPLY(a_error_zeroes, clock, reset, rsp_strobe && rsp_data.range_error, (rsp_data.day_number_out == 23'd0) && (rsp_data.year_out == 14'd0) && (rsp_data.weekday == 3'd0) && !rsp_data.is_business_day)
   `ASSERT_DELAYED(a_jdn_echo, clock, reset, start && !busy && req_data.op, 9, rsp_data.range_error || (rsp_data.day_number_out == $past(req_data.day_number_in, 9)))
   `ASSERT_IMPLY(a_weekday_flag, clock, reset, rsp_strobe && !rsp_data.range_error, (rsp_data.weekday != 3'd0) && (rsp_data.is_business_day == ((rsp_data.weekday != gjdc_pkg::SUNDAY) && (rsp_data.weekday != gjdc_pkg::SATURDAY))))

endmodule

bind gregorian_julian_day_converter_unit gjdc_checker u_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_data(req_data),
   .rsp_strobe(rsp_strobe),
   .rsp_data(rsp_data)
);
